// ===== sv/block_rms_envelope_follower_macros.svh =====
// Assertion macros shared by the RMS envelope follower RTL.
`ifndef BLOCK_RMS_ENVELOPE_FOLLOWER_MACROS_SVH
`define BLOCK_RMS_ENVELOPE_FOLLOWER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge out of reset.
`define RMSEF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define RMSEF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RMSEF_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define RMSEF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/rmsef_pkg.sv =====
// Constants, types and register codes of the RMS envelope follower.
package rmsef_pkg;

  localparam int SampleBits = 16;
  localparam int MaxBlock   = 4096;
  localparam int SumBits    = 42;
  localparam int LenBits    = 13;
  localparam int CoefBits   = 16;
  localparam int LevelBits  = 16;
  localparam int SensFrac   = 12;
  localparam int CfgIdxBits = 2;
  localparam int CfgDataBits = 16;

  // The mean of squares is Q0.(2*(SampleBits-1)); it is moved to Q0.32.
  localparam int MeanShift  = 32 - 2 * (SampleBits - 1);
  localparam int RootBits   = (SumBits + MeanShift) / 2;
  localparam int RemBits    = RootBits + 1;
  localparam int TrialBits  = RootBits + 3;
  localparam int MagBits    = SampleBits + 1;
  localparam int SquareBits = 2 * SampleBits - 1;
  localparam int MulABits   = RootBits;
  localparam int MulBBits   = CoefBits + 1;
  localparam int ProdBits   = MulABits + MulBBits;
  localparam int AccBits    = 2 * LevelBits + 1;
  localparam int StepBits   = $clog2(SumBits);

  typedef logic [CfgIdxBits-1:0] cfg_idx_t;
  typedef logic [CfgDataBits-1:0] cfg_data_t;
  typedef logic signed [SampleBits-1:0] sample_t;
  typedef logic [LevelBits-1:0] level_t;

  localparam cfg_idx_t RegBlockLength  = 2'd0;
  localparam cfg_idx_t RegAttackCoeff  = 2'd1;
  localparam cfg_idx_t RegReleaseCoeff = 2'd2;
  localparam cfg_idx_t RegSensitivity  = 2'd3;

endpackage

// ===== sv/rmsef_ifs.sv =====
// Valid/ready stream interfaces for samples and for envelope results.
interface rmsef_sample_if;
  import rmsef_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface rmsef_result_if;
  import rmsef_pkg::*;

  logic   valid;
  logic   ready;
  level_t envelope;
  level_t level;

  modport source (output valid, output envelope, output level, input ready);
  modport sink (input valid, input envelope, input level, output ready);
endinterface

// ===== sv/block_rms_envelope_follower.sv =====
// Block RMS envelope follower with attack and release poles, sequenced datapath.
//
//   channel    direction  transfer moves
//   sample_i   in         one signed Q1.15 audio sample
//   result_o   out        envelope and level, both Q0.16, once per completed block
//   cfg_*      in         register write: index, data, write enable
//
// A sample that does not complete a block passes through capture, square and accumulate.
// The sample that completes a block goes on through divide, root, scale, level, filter and done: one shared
// subtractor runs a restoring divide (one quotient bit per cycle) and then a
// digit-by-digit square root (one root bit per cycle); one shared multiplier does the
// square, the sensitivity scaling and the two filter products.
// Reset is asynchronous and active low; it loads the register defaults and clears state.
// If the previous result has not been transferred, the block holds in its final step.
`include "block_rms_envelope_follower_macros.svh"

module block_rms_envelope_follower (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  rmsef_pkg::cfg_idx_t  cfg_idx_i,
  input  rmsef_pkg::cfg_data_t cfg_data_i,
  rmsef_sample_if.sink         sample_i,
  rmsef_result_if.source       result_o
);
  import rmsef_pkg::*;

  // One-hot sequencer states.
  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_SQUARE = 10'b00_0000_0010,
    ST_ACCUM  = 10'b00_0000_0100,
    ST_DIV    = 10'b00_0000_1000,
    ST_SQRT   = 10'b00_0001_0000,
    ST_SCALE  = 10'b00_0010_0000,
    ST_LEVEL  = 10'b00_0100_0000,
    ST_ENV_A  = 10'b00_1000_0000,
    ST_ENV_B  = 10'b01_0000_0000,
    ST_DONE   = 10'b10_0000_0000
  } state_e;

  // Configuration registers.
  logic [LenBits-1:0]   block_length_q;
  logic [CoefBits-1:0]  attack_coeff_q;
  logic [CoefBits-1:0]  release_coeff_q;
  logic [CoefBits-1:0]  sensitivity_q;

  // Control state.
  state_e               state_q, state_d;
  logic [StepBits-1:0]  step_q, step_d;
  logic [LenBits-1:0]   count_q, count_d;
  logic [SumBits-1:0]   sum_q, sum_d;
  level_t               env_q, env_d;
  logic                 out_valid_q, out_valid_d;

  // Datapath registers.
  sample_t                          sample_q, sample_d;
  logic [ProdBits-1:0]              prod_q, prod_d;
  logic [SumBits+MeanShift-1:0]     work_q, work_d;
  logic [RemBits-1:0]               rem_q, rem_d;
  logic [RootBits-1:0]              root_q, root_d;
  logic [AccBits-1:0]               acc_q, acc_d;
  level_t                           level_q, level_d;
  logic [CoefBits-1:0]              coeff_q, coeff_d;
  level_t                           lvl_out_q, lvl_out_d;

  // Shared units.
  logic [MulABits-1:0]  mul_a;
  logic [MulBBits-1:0]  mul_b;
  logic [ProdBits-1:0]  mul_p;
  logic [TrialBits-1:0] sub_a, sub_b;
  logic [TrialBits:0]   sub_diff;
  logic                 sub_ge;

  logic [MagBits-1:0]   sample_ext, mag;
  logic [LenBits-1:0]   len_eff, count_inc, div_trial;
  logic [SumBits:0]     sum_ext;
  logic [SumBits-1:0]   sum_sat;
  level_t               level_clamped;
  logic [AccBits:0]     env_total;
  logic                 in_xfer, out_xfer;

  assign in_xfer  = sample_i.valid & sample_i.ready;
  assign out_xfer = result_o.valid & result_o.ready;

  assign sample_i.ready   = (state_q == ST_IDLE);
  assign result_o.valid   = out_valid_q;
  assign result_o.envelope = env_q;
  assign result_o.level    = lvl_out_q;

  // A zero length acts as one; lengths above the maximum saturate.
  always_comb begin
    if (block_length_q == '0) begin
      len_eff = LenBits'(1);
    end else if (block_length_q > LenBits'(MaxBlock)) begin
      len_eff = LenBits'(MaxBlock);
    end else begin
      len_eff = block_length_q;
    end
  end

  // Magnitude of the sample; the most negative code maps to 2^(SampleBits-1).
  assign sample_ext = {sample_q[SampleBits-1], sample_q};
  assign mag = sample_ext[MagBits-1] ? (~sample_ext + MagBits'(1)) : sample_ext;

  // Restoring-divide trial value: previous remainder with the next dividend bit.
  assign div_trial = {rem_q[LenBits-2:0], work_q[SumBits-1]};

  // Shared multiplier operand selection.
  always_comb begin
    case (state_q)
      ST_SQUARE: begin
        mul_a = MulABits'(mag);
        mul_b = MulBBits'(mag);
      end
      ST_SCALE: begin
        mul_a = root_q;
        mul_b = MulBBits'(sensitivity_q);
      end
      ST_ENV_A: begin
        mul_a = MulABits'(env_q);
        mul_b = MulBBits'(coeff_q);
      end
      ST_ENV_B: begin
        mul_a = MulABits'(level_q);
        mul_b = MulBBits'(1 << CoefBits) - MulBBits'(coeff_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = ProdBits'(mul_a) * ProdBits'(mul_b);

  // Shared compare-and-subtract: divide step or square-root step.
  always_comb begin
    case (state_q)
      ST_DIV: begin
        sub_a = TrialBits'(div_trial);
        sub_b = TrialBits'(len_eff);
      end
      ST_SQRT: begin
        sub_a = {rem_q, work_q[SumBits-1 -: 2]};
        sub_b = TrialBits'({root_q, 2'b01});
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = ~sub_diff[TrialBits];

  // Accumulate the square with saturation at the top of the sum range.
  assign sum_ext   = {1'b0, sum_q} + (SumBits+1)'(prod_q[SquareBits-1:0]);
  assign sum_sat   = sum_ext[SumBits] ? '1 : sum_ext[SumBits-1:0];
  assign count_inc = count_q + LenBits'(1);

  // Level is the scaled root in Q0.16, saturated just under one.
  assign level_clamped = (prod_q[ProdBits-1:SensFrac+LevelBits] != '0) ? '1 :
                         prod_q[SensFrac+LevelBits-1:SensFrac];

  // Filter output: rounding term already sits in the accumulator.
  assign env_total = (AccBits+1)'(acc_q) + (AccBits+1)'(prod_q[AccBits-1:0]);

  // Sequencer and datapath next state.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    count_d     = count_q;
    sum_d       = sum_q;
    env_d       = env_q;
    out_valid_d = out_valid_q & ~out_xfer;
    sample_d    = sample_q;
    prod_d      = prod_q;
    work_d      = work_q;
    rem_d       = rem_q;
    root_d      = root_q;
    acc_d       = acc_q;
    level_d     = level_q;
    coeff_d     = coeff_q;
    lvl_out_d   = lvl_out_q;

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          sample_d = sample_i.sample;
          state_d  = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        prod_d  = mul_p;
        state_d = ST_ACCUM;
      end
      ST_ACCUM: begin
        sum_d   = sum_sat;
        count_d = count_inc;
        if (count_inc >= len_eff) begin
          work_d  = (SumBits+MeanShift)'(sum_sat);
          rem_d   = '0;
          step_d  = StepBits'(SumBits - 1);
          state_d = ST_DIV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        // Quotient bits enter at the bottom as dividend bits leave at the top.
        work_d = {work_q[SumBits+MeanShift-2:0], sub_ge};
        rem_d  = RemBits'(sub_ge ? sub_diff[LenBits-1:0] : div_trial);
        if (step_q == '0) begin
          rem_d   = '0;
          root_d  = '0;
          step_d  = StepBits'(RootBits - 1);
          state_d = ST_SQRT;
        end else begin
          step_d = step_q - StepBits'(1);
        end
      end
      ST_SQRT: begin
        // Two bits of the scaled mean per step, one root bit out.
        work_d = work_q << 2;
        rem_d  = sub_ge ? sub_diff[RemBits-1:0] : sub_a[RemBits-1:0];
        root_d = {root_q[RootBits-2:0], sub_ge};
        if (step_q == '0) begin
          state_d = ST_SCALE;
        end else begin
          step_d = step_q - StepBits'(1);
        end
      end
      ST_SCALE: begin
        prod_d  = mul_p;
        state_d = ST_LEVEL;
      end
      ST_LEVEL: begin
        level_d = level_clamped;
        coeff_d = (level_clamped > env_q) ? attack_coeff_q : release_coeff_q;
        state_d = ST_ENV_A;
      end
      ST_ENV_A: begin
        prod_d  = mul_p;
        state_d = ST_ENV_B;
      end
      ST_ENV_B: begin
        acc_d   = AccBits'(prod_q[2*LevelBits-1:0]) + AccBits'(1 << (LevelBits - 1));
        prod_d  = mul_p;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || result_o.ready) begin
          env_d       = (env_total[AccBits:2*LevelBits] != '0) ? '1 :
                        env_total[2*LevelBits-1:LevelBits];
          lvl_out_d   = level_q;
          out_valid_d = 1'b1;
          sum_d       = '0;
          count_d     = '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_length_q  <= LenBits'(256);
      attack_coeff_q  <= '0;
      release_coeff_q <= '0;
      sensitivity_q   <= CoefBits'(4096);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegBlockLength:  block_length_q  <= cfg_data_i[LenBits-1:0];
        RegAttackCoeff:  attack_coeff_q  <= cfg_data_i[CoefBits-1:0];
        RegReleaseCoeff: release_coeff_q <= cfg_data_i[CoefBits-1:0];
        RegSensitivity:  sensitivity_q   <= cfg_data_i[CoefBits-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      env_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      count_q     <= count_d;
      sum_q       <= sum_d;
      env_q       <= env_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers carry no reset.
  always_ff @(posedge clk_i) begin
    sample_q  <= sample_d;
    prod_q    <= prod_d;
    work_q    <= work_d;
    rem_q     <= rem_d;
    root_q    <= root_d;
    acc_q     <= acc_d;
    level_q   <= level_d;
    coeff_q   <= coeff_d;
    lvl_out_q <= lvl_out_d;
  end

  `RMSEF_ASSERT_NEXT(a_accept_starts_square, clk_i, rst_ni, in_xfer, state_q == ST_SQUARE, "accepted sample did not start squaring")
  `RMSEF_ASSERT_IMPL(a_count_in_range, clk_i, rst_ni, 1'b1, count_q <= LenBits'(MaxBlock), "sample count beyond maximum block")
  `RMSEF_ASSERT_IMPL(a_div_rem_below_len, clk_i, rst_ni, state_q == ST_DIV, rem_q < RemBits'(len_eff), "divide remainder not below length")
  `RMSEF_ASSERT_IMPL(a_result_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q == ST_DONE), "result raised outside final step")

endmodule
